### hdl/uv_sphere_vertex_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// UV sphere vertex generator assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define UVS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("uvs assertion failed");

// Next-cycle implication
`define UVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("uvs assertion failed");

`endif

### hdl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Widths, register codes, the quarter-wave sine ROM and the reciprocal
// table used by the pipelined constant-divisor dividers.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int MAX_DIVISIONS   = 256;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_LEN        = (1 << SINE_TABLE_BITS) + 1;
    localparam int SINE_AW         = SINE_TABLE_BITS + 1;
    localparam int RECIP_AW        = $clog2(MAX_DIVISIONS);
    localparam int RECIP_SHIFT     = 25;
    localparam int RECIP_W         = 25;
    localparam int IDX_W           = 9;
    localparam int TEX_W           = 17;
    localparam int POS_W           = 17;
    localparam int NORM_W          = 16;
    localparam int RAD_W           = 16;
    localparam int DIV_SHIFT_FULL  = 16;
    localparam int DIV_SHIFT_HALF  = 15;

    // Configuration register indexes
    localparam logic [1:0] CFG_RADIUS  = 2'd0;
    localparam logic [1:0] CFG_SECTORS = 2'd1;
    localparam logic [1:0] CFG_STACKS  = 2'd2;

    typedef logic [14:0]        sine_tbl_t  [SINE_LEN];
    typedef logic [RECIP_W-1:0] recip_tbl_t [MAX_DIVISIONS];

    // Per-item quad data carried beside the arithmetic
    typedef struct packed {
        logic             quad_valid;
        logic [TEX_W-1:0] upper_index;
        logic [TEX_W-1:0] lower_index;
    } quad_t;

    // Entry k: sin(pi/2 * k / 2^B) in Q0.15 from a Q2.30 Taylor series
    function automatic sine_tbl_t build_sine();
        sine_tbl_t   tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        for (int k = 0; k < SINE_LEN; k++) begin
            x    = (64'(k) * 64'd1686629713) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            sum  = x;
            term = ((x * x2) >> 30) / 64'd6;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd210;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + term;
            q    = (sum + 64'd16384) >> 15;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            tbl[k] = q[14:0];
        end
        return tbl;
    endfunction

    // Entry d-1: floor(2^25 / d) by shift-subtract long division, 0 for d = 1
    function automatic recip_tbl_t build_recip();
        recip_tbl_t  tbl;
        logic [26:0] rem;
        logic [26:0] dv;
        logic [26:0] quo;
        for (int k = 0; k < MAX_DIVISIONS; k++) begin
            dv  = 27'(k + 1);
            rem = '0;
            quo = '0;
            for (int b = RECIP_SHIFT; b >= 0; b--) begin
                rem = {rem[25:0], (b == RECIP_SHIFT) ? 1'b1 : 1'b0};
                quo = {quo[25:0], 1'b0};
                if (rem >= dv) begin
                    rem    = rem - dv;
                    quo[0] = 1'b1;
                end
            end
            tbl[k] = (k < 1) ? '0 : quo[RECIP_W-1:0];
        end
        return tbl;
    endfunction

    localparam sine_tbl_t  SINE_ROM  = build_sine();
    localparam recip_tbl_t RECIP_ROM = build_recip();

endpackage

### hdl/uvs_div.sv
// ----------------------------------------------------------------------------
// UV sphere rounded divider
// Four-stage pipeline computing (idx * 2^NUM_SHIFT + divisor/2) / divisor
// by a reciprocal multiply and one compare-subtract correction.
// ----------------------------------------------------------------------------
module uvs_div #(
    parameter int NUM_SHIFT = uvs_pkg::DIV_SHIFT_FULL
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [uvs_pkg::IDX_W-1:0]   idx,
    input  logic [uvs_pkg::IDX_W-1:0]   divisor,
    output logic [uvs_pkg::TEX_W-1:0]   quot
);
    import uvs_pkg::*;

    localparam int NUM_W  = IDX_W + NUM_SHIFT;
    localparam int HALF_W = IDX_W - 1;
    localparam int A_W    = IDX_W + RECIP_W;
    localparam int B_W    = HALF_W + RECIP_W;
    localparam int SUM_W  = A_W + NUM_SHIFT + 1;
    localparam int P_W    = TEX_W + IDX_W;

    logic [RECIP_W-1:0] recip;
    logic [HALF_W-1:0]  half;
    logic [NUM_W-1:0]   num;
    logic [SUM_W-1:0]   sum;
    logic [NUM_W-1:0]   rem;

    logic [A_W-1:0]     a_reg;
    logic [B_W-1:0]     b_reg;
    logic [NUM_W-1:0]   n1_reg;
    logic [TEX_W-1:0]   qe2_reg;
    logic [NUM_W-1:0]   n2_reg;
    logic [P_W-1:0]     p3_reg;
    logic [TEX_W-1:0]   qe3_reg;
    logic [NUM_W-1:0]   n3_reg;
    logic [TEX_W-1:0]   q_reg;

    // Numerator and reciprocal lookup
    assign recip = RECIP_ROM[RECIP_AW'(divisor - IDX_W'(1))];
    assign half  = divisor[IDX_W-1:1];
    assign num   = {idx, NUM_SHIFT'(0)} + NUM_W'(half);

    // Estimate and remainder
    assign sum = (SUM_W'(a_reg) << NUM_SHIFT) + SUM_W'(b_reg);
    assign rem = n3_reg - p3_reg[NUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= A_W'(idx) * A_W'(recip);
            b_reg   <= B_W'(half) * B_W'(recip);
            n1_reg  <= num;
            qe2_reg <= sum[RECIP_SHIFT +: TEX_W];
            n2_reg  <= n1_reg;
            p3_reg  <= P_W'(qe2_reg) * P_W'(divisor);
            qe3_reg <= qe2_reg;
            n3_reg  <= n2_reg;
            q_reg   <= qe3_reg + TEX_W'(rem >= NUM_W'(divisor));
        end
    end

    assign quot = q_reg;

endmodule

### hdl/uv_sphere_vertex_generator_unit.sv
// Accepts one vertex per cycle while no result is held by m_ready low; a request
// passes through each register stage below before m_valid rises for its result.
// Ten register stages: input, four divider stages, sine ROM, normal product,
// normal rounding, radius product, output rounding.
// A result held by m_ready low stalls the whole pipeline in place.
// Reset (aresetn low, synchronous): pipeline emptied, radius 256, 36 sectors, 18 stacks.
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Streams grid points in and returns vertex position, normal, texture
// coordinates and quad start indices for each one.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_unit_assert.svh"

module uv_sphere_vertex_generator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [uvs_pkg::IDX_W-1:0]           s_stack_row,
    input  logic [uvs_pkg::IDX_W-1:0]           s_sector_col,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [uvs_pkg::POS_W-1:0]    m_pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]    m_pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]    m_pos_z,
    output logic signed [uvs_pkg::NORM_W-1:0]   m_norm_x,
    output logic signed [uvs_pkg::NORM_W-1:0]   m_norm_y,
    output logic signed [uvs_pkg::NORM_W-1:0]   m_norm_z,
    output logic [uvs_pkg::TEX_W-1:0]           m_tex_u,
    output logic [uvs_pkg::TEX_W-1:0]           m_tex_v,
    output logic                                m_quad_valid,
    output logic [uvs_pkg::TEX_W-1:0]           m_upper_index,
    output logic [uvs_pkg::TEX_W-1:0]           m_lower_index
);
    import uvs_pkg::*;

    localparam int STAGES    = 10;
    localparam int DIV_LAT   = 4;
    localparam int TAIL      = STAGES - DIV_LAT - 1;
    localparam int PROD_W    = 2 * NORM_W;
    localparam int RPROD_W   = RAD_W + NORM_W + 1;
    localparam int RND_IN_W  = RPROD_W + 1;

    typedef struct packed {
        quad_t            quad;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } carry_t;

    // Shift by 15 with rounding half away from zero
    function automatic logic signed [RND_IN_W-1:0] round_q15(
        input logic signed [RND_IN_W-1:0] p
    );
        logic [RND_IN_W-1:0] mag;
        logic [RND_IN_W-1:0] r;
        mag = p[RND_IN_W-1] ? RND_IN_W'(-p) : RND_IN_W'(p);
        r   = (mag + RND_IN_W'(16384)) >> 15;
        return p[RND_IN_W-1] ? -$signed(r) : $signed(r);
    endfunction

    // Quarter-wave ROM address for a 16-bit phase
    function automatic logic [SINE_AW-1:0] rom_addr(input logic [15:0] ph);
        logic [SINE_AW-1:0] a;
        a = SINE_AW'(ph[13 -: SINE_TABLE_BITS]);
        return ph[14] ? SINE_AW'(SINE_LEN - 1) - a : a;
    endfunction

    logic [RAD_W-1:0]       radius_reg;
    logic [IDX_W-1:0]       sectors_reg;
    logic [IDX_W-1:0]       stacks_reg;
    logic [IDX_W-1:0]       s_cnt;
    logic [IDX_W-1:0]       t_cnt;

    logic                   en;
    logic [STAGES-1:0]      vld_reg;
    logic [IDX_W-1:0]       row_reg;
    logic [IDX_W-1:0]       col_reg;
    logic [IDX_W-1:0]       row_clamp;
    logic [IDX_W-1:0]       col_clamp;
    quad_t                  quad_next;
    quad_t                  quad_reg [DIV_LAT];
    carry_t                 carry_reg [TAIL];

    logic [TEX_W-1:0]       u_q;
    logic [TEX_W-1:0]       v_q;
    logic [TEX_W-1:0]       lat_q;
    logic [15:0]            lat;
    logic [15:0]            lon;

    logic [14:0]            sl_reg, cl_reg, so_reg, co_reg;
    logic                   sl_neg_reg, cl_neg_reg, so_neg_reg, co_neg_reg;
    logic signed [NORM_W-1:0] sl, cl, so, co;
    logic signed [PROD_W-1:0] px_reg, pz_reg;
    logic signed [NORM_W-1:0] ny6_reg;
    logic signed [NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [RPROD_W-1:0] rx_reg, ry_reg, rz_reg;
    logic signed [NORM_W-1:0] nx8_reg, ny8_reg, nz8_reg;
    logic signed [POS_W-1:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [NORM_W-1:0] nx9_reg, ny9_reg, nz9_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RAD_W'(256);
            sectors_reg <= IDX_W'(36);
            stacks_reg  <= IDX_W'(18);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RADIUS:  radius_reg  <= cfg_data;
                CFG_SECTORS: sectors_reg <= cfg_data[IDX_W-1:0];
                CFG_STACKS:  stacks_reg  <= cfg_data[IDX_W-1:0];
                default:     ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // Clamped counts
    always_comb begin
        s_cnt = sectors_reg;
        if (sectors_reg < IDX_W'(3)) s_cnt = IDX_W'(3);
        else if (sectors_reg > IDX_W'(MAX_DIVISIONS)) s_cnt = IDX_W'(MAX_DIVISIONS);
        t_cnt = stacks_reg;
        if (stacks_reg < IDX_W'(2)) t_cnt = IDX_W'(2);
        else if (stacks_reg > IDX_W'(MAX_DIVISIONS)) t_cnt = IDX_W'(MAX_DIVISIONS);
    end

    // Pipeline advance: move whenever the output slot is free or taken
    assign en      = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_valid};
        end
    end

    // Input stage with index clamping
    assign row_clamp = (s_stack_row > t_cnt) ? t_cnt : s_stack_row;
    assign col_clamp = (s_sector_col > s_cnt) ? s_cnt : s_sector_col;

    always_ff @(posedge aclk) begin
        if (en) begin
            row_reg <= row_clamp;
            col_reg <= col_clamp;
        end
    end

    // Quad start indices, carried alongside the dividers
    always_comb begin
        quad_next.quad_valid  = (row_reg < t_cnt) && (col_reg < s_cnt);
        quad_next.upper_index = '0;
        quad_next.lower_index = '0;
        if (quad_next.quad_valid) begin
            quad_next.upper_index = TEX_W'(row_reg) * (TEX_W'(s_cnt) + TEX_W'(1))
                                    + TEX_W'(col_reg);
            quad_next.lower_index = quad_next.upper_index + TEX_W'(s_cnt) + TEX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_reg[0] <= quad_next;
            for (int k = 1; k < DIV_LAT; k++) begin
                quad_reg[k] <= quad_reg[k-1];
            end
        end
    end

    // Texture coordinates and latitude angle
    uvs_div #(.NUM_SHIFT(DIV_SHIFT_FULL)) u_div_u (
        .aclk(aclk), .en(en), .idx(col_reg), .divisor(s_cnt), .quot(u_q)
    );
    uvs_div #(.NUM_SHIFT(DIV_SHIFT_FULL)) u_div_v (
        .aclk(aclk), .en(en), .idx(row_reg), .divisor(t_cnt), .quot(v_q)
    );
    uvs_div #(.NUM_SHIFT(DIV_SHIFT_HALF)) u_div_lat (
        .aclk(aclk), .en(en), .idx(row_reg), .divisor(t_cnt), .quot(lat_q)
    );

    assign lon = u_q[15:0];
    assign lat = 16'd16384 - lat_q[15:0];

    // Sine ROM reads
    always_ff @(posedge aclk) begin
        if (en) begin
            sl_reg     <= SINE_ROM[rom_addr(lat)];
            cl_reg     <= SINE_ROM[rom_addr(lat + 16'd16384)];
            so_reg     <= SINE_ROM[rom_addr(lon)];
            co_reg     <= SINE_ROM[rom_addr(lon + 16'd16384)];
            sl_neg_reg <= lat[15];
            cl_neg_reg <= (lat + 16'd16384) >> 15 != 16'd0;
            so_neg_reg <= lon[15];
            co_neg_reg <= (lon + 16'd16384) >> 15 != 16'd0;
            carry_reg[0] <= '{quad: quad_reg[DIV_LAT-1], tex_u: u_q, tex_v: v_q};
            for (int k = 1; k < TAIL; k++) begin
                carry_reg[k] <= carry_reg[k-1];
            end
        end
    end

    // Signed table values
    assign sl = sl_neg_reg ? -$signed({1'b0, sl_reg}) : $signed({1'b0, sl_reg});
    assign cl = cl_neg_reg ? -$signed({1'b0, cl_reg}) : $signed({1'b0, cl_reg});
    assign so = so_neg_reg ? -$signed({1'b0, so_reg}) : $signed({1'b0, so_reg});
    assign co = co_neg_reg ? -$signed({1'b0, co_reg}) : $signed({1'b0, co_reg});

    // Normal products, rounding, radius products, output rounding
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg    <= cl * co;
            pz_reg    <= cl * so;
            ny6_reg   <= sl;
            nx_reg    <= NORM_W'(round_q15(RND_IN_W'(px_reg)));
            nz_reg    <= NORM_W'(round_q15(RND_IN_W'(pz_reg)));
            ny_reg    <= ny6_reg;
            rx_reg    <= $signed({1'b0, radius_reg}) * nx_reg;
            ry_reg    <= $signed({1'b0, radius_reg}) * ny_reg;
            rz_reg    <= $signed({1'b0, radius_reg}) * nz_reg;
            nx8_reg   <= nx_reg;
            ny8_reg   <= ny_reg;
            nz8_reg   <= nz_reg;
            pos_x_reg <= POS_W'(round_q15(RND_IN_W'(rx_reg)));
            pos_y_reg <= POS_W'(round_q15(RND_IN_W'(ry_reg)));
            pos_z_reg <= POS_W'(round_q15(RND_IN_W'(rz_reg)));
            nx9_reg   <= nx8_reg;
            ny9_reg   <= ny8_reg;
            nz9_reg   <= nz8_reg;
        end
    end

    assign m_valid       = vld_reg[STAGES-1];
    assign m_pos_x       = pos_x_reg;
    assign m_pos_y       = pos_y_reg;
    assign m_pos_z       = pos_z_reg;
    assign m_norm_x      = nx9_reg;
    assign m_norm_y      = ny9_reg;
    assign m_norm_z      = nz9_reg;
    assign m_tex_u       = carry_reg[TAIL-1].tex_u;
    assign m_tex_v       = carry_reg[TAIL-1].tex_v;
    assign m_quad_valid  = carry_reg[TAIL-1].quad.quad_valid;
    assign m_upper_index = carry_reg[TAIL-1].quad.upper_index;
    assign m_lower_index = carry_reg[TAIL-1].quad.lower_index;

    // Checks
    `UVS_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, vld_reg[0])
    `UVS_ASSERT_IMPL(a_no_quad_zero, aclk, aresetn, m_valid && !m_quad_valid, m_upper_index == '0 && m_lower_index == '0)
    `UVS_ASSERT_IMPL(a_lower_offset, aclk, aresetn, m_valid && m_quad_valid, m_lower_index == m_upper_index + TEX_W'(s_cnt) + TEX_W'(1))
    `UVS_ASSERT_IMPL(a_tex_range, aclk, aresetn, m_valid, m_tex_u <= TEX_W'(65536) && m_tex_v <= TEX_W'(65536))

endmodule
